/* rtl/core/ptst_pkg.sv */
// ----------------------------------------------------------------------------
// ptst_pkg
// Shared widths, command and status codes, and the slot store write bundle
// for the periodic timer slot table.
// ----------------------------------------------------------------------------
package ptst_pkg;

  localparam int SLOT_COUNT_DEF = 8;

  localparam int CMD_W      = 2;
  localparam int OWNER_W    = 8;
  localparam int PERIOD_W   = 32;
  localparam int STEP_W     = 16;
  localparam int SLOT_IDX_W = 3;
  localparam int STATUS_W   = 2;

  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  // One write into the slot store: claim loads owner, period and count
  // (count = period); upd rewrites the elapsed count only.
  typedef struct packed {
    logic                claim;
    logic                upd;
    logic [OWNER_W-1:0]  owner;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] elapsed;
  } slot_wr_t;

endpackage

/* rtl/core/ptst_in_if.sv */
// ----------------------------------------------------------------------------
// ptst_in_if
// Command channel: tick, add or remove items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ptst_in_if;
  import ptst_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [OWNER_W-1:0]  owner_id;
  logic [PERIOD_W-1:0] period_ticks;

  modport source (output valid, output cmd, output owner_id, output period_ticks,
                  input ready);
  modport sink   (input valid, input cmd, input owner_id, input period_ticks,
                  output ready);
endinterface

/* rtl/core/ptst_out_if.sv */
// ----------------------------------------------------------------------------
// ptst_out_if
// Result channel: one item per firing, claimed or freed slot, or error.
// ----------------------------------------------------------------------------
interface ptst_out_if;
  import ptst_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  fired;
  logic [OWNER_W-1:0]    fired_owner;
  logic [SLOT_IDX_W-1:0] slot_index;
  logic [STATUS_W-1:0]   status;
  logic                  last;

  modport source (output valid, output fired, output fired_owner, output slot_index,
                  output status, output last, input ready);
  modport sink   (input valid, input fired, input fired_owner, input slot_index,
                  input status, input last, output ready);
endinterface

/* rtl/core/ptst_slot_store.sv */
// ----------------------------------------------------------------------------
// ptst_slot_store
// Owner, period and elapsed count per slot; one write port and one
// registered read port sharing the sequencer's slot address.
// ----------------------------------------------------------------------------
module ptst_slot_store #(
  parameter int SLOT_COUNT = ptst_pkg::SLOT_COUNT_DEF,
  parameter int IDX_W      = 3
) (
  input  logic                          clk,
  input  logic [IDX_W-1:0]              addr,
  input  ptst_pkg::slot_wr_t            wr,
  output logic [ptst_pkg::OWNER_W-1:0]  rd_owner_r,
  output logic [ptst_pkg::PERIOD_W-1:0] rd_period_r,
  output logic [ptst_pkg::PERIOD_W-1:0] rd_elapsed_r
);
  import ptst_pkg::*;

  logic [OWNER_W-1:0]  owner_mem   [SLOT_COUNT];
  logic [PERIOD_W-1:0] period_mem  [SLOT_COUNT];
  logic [PERIOD_W-1:0] elapsed_mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (wr.claim) begin
      owner_mem[addr]   <= wr.owner;
      period_mem[addr]  <= wr.period;
      elapsed_mem[addr] <= wr.period;
    end else if (wr.upd) begin
      elapsed_mem[addr] <= wr.elapsed;
    end
  end

  always_ff @(posedge clk) begin
    rd_owner_r   <= owner_mem[addr];
    rd_period_r  <= period_mem[addr];
    rd_elapsed_r <= elapsed_mem[addr];
  end

endmodule

/* rtl/core/periodic_timer_slot_table_unit.sv */
// ----------------------------------------------------------------------------
// periodic_timer_slot_table_unit
// Table of periodic timer slots driven by tick, add and remove items.
// ----------------------------------------------------------------------------
// Each accepted item is handled by one walk over the slots, lowest first,
// with one shared 33-bit saturating adder and comparator. Each slot visited
// has a store read state, then an update and write-back state. A tick or a
// remove walks every slot, an add stops at the first free slot and claims it
// (skipping the walk when the table is already full), and an unused command
// code is dropped from idle. The walk pauses at a hit while a pending result
// waits and the output register still holds an untaken item. in_chan.ready
// is high only between items. Results for an item come out in slot order;
// the final one carries last. Owner, period and count are undefined until a
// slot is claimed; the valid bits and the active count clear on reset.
module periodic_timer_slot_table_unit #(
  parameter int SLOT_COUNT = ptst_pkg::SLOT_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [ptst_pkg::STEP_W-1:0] cfg_wdata,
  ptst_in_if.sink                     in_chan,
  ptst_out_if.source                  out_chan
);
  import ptst_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int ACT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);
  localparam logic [ACT_W-1:0] ACT_FULL = ACT_W'(SLOT_COUNT);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_EXEC  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  typedef struct packed {
    logic                  fired;
    logic [OWNER_W-1:0]    fired_owner;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [STATUS_W-1:0]   status;
    logic                  last;
  } result_t;

  state_t                state_r, state_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [CMD_W-1:0]      cmd_r, cmd_nxt;
  logic [OWNER_W-1:0]    owner_r, owner_nxt;
  logic [PERIOD_W-1:0]   period_r, period_nxt;
  logic [STEP_W-1:0]     step_r;
  logic [SLOT_COUNT-1:0] valid_r, valid_nxt;
  logic [ACT_W-1:0]      active_r, active_nxt;
  result_t               pend_r, pend_nxt;
  logic                  pend_v_r, pend_v_nxt;
  result_t               out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;

  slot_wr_t              wr;
  logic [OWNER_W-1:0]    rd_owner;
  logic [PERIOD_W-1:0]   rd_period;
  logic [PERIOD_W-1:0]   rd_elapsed;

  logic                  out_free;
  logic                  slot_v;
  logic [PERIOD_W:0]     sum;
  logic [PERIOD_W-1:0]   sum_sat;
  logic                  fire;
  logic                  hit;
  logic                  scan_done;
  result_t               hit_res;

  ptst_slot_store #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk          (clk),
    .addr         (idx_r),
    .wr           (wr),
    .rd_owner_r   (rd_owner),
    .rd_period_r  (rd_period),
    .rd_elapsed_r (rd_elapsed)
  );

  assign in_chan.ready        = (state_r == S_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.fired       = out_r.fired;
  assign out_chan.fired_owner = out_r.fired_owner;
  assign out_chan.slot_index  = out_r.slot_index;
  assign out_chan.status      = out_r.status;
  assign out_chan.last        = out_r.last;

  assign out_free = !out_valid_r || out_chan.ready;
  assign slot_v   = valid_r[idx_r];

  // Shared unit: saturating count update and period compare
  assign sum     = {1'b0, rd_elapsed} + (PERIOD_W + 1)'(step_r);
  assign sum_sat = sum[PERIOD_W] ? {PERIOD_W{1'b1}} : sum[PERIOD_W-1:0];
  assign fire    = (sum_sat >= rd_period);

  always_comb begin
    hit = 1'b0;
    case (cmd_r)
      CMD_TICK:   hit = slot_v && fire;
      CMD_ADD:    hit = !slot_v;
      CMD_REMOVE: hit = slot_v && (rd_owner == owner_r);
      default:    hit = 1'b0;
    endcase
  end

  assign scan_done = (idx_r == IDX_LAST) || ((cmd_r == CMD_ADD) && hit);

  always_comb begin
    hit_res             = '0;
    hit_res.fired       = (cmd_r == CMD_TICK);
    hit_res.fired_owner = (cmd_r == CMD_TICK) ? rd_owner : '0;
    hit_res.slot_index  = SLOT_IDX_W'(idx_r);
    hit_res.status      = ST_OK;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cmd_nxt       = cmd_r;
    owner_nxt     = owner_r;
    period_nxt    = period_r;
    valid_nxt     = valid_r;
    active_nxt    = active_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    wr            = '0;
    wr.owner      = owner_r;
    wr.period     = period_r;
    wr.elapsed    = fire ? '0 : sum_sat;

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          cmd_nxt    = in_chan.cmd;
          owner_nxt  = in_chan.owner_id;
          period_nxt = in_chan.period_ticks;
          idx_nxt    = '0;
          case (in_chan.cmd)
            CMD_TICK, CMD_REMOVE: state_nxt = S_READ;
            CMD_ADD:              state_nxt = (active_r == ACT_FULL) ? S_FLUSH : S_READ;
            default:              state_nxt = S_IDLE;
          endcase
        end
      end
      S_READ: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        // on a hit, hold while an earlier result still blocks the output register
        if (!(hit && pend_v_r && !out_free)) begin
          case (cmd_r)
            CMD_TICK: wr.upd = slot_v;
            CMD_ADD: begin
              wr.claim = hit;
              if (hit) begin
                valid_nxt[idx_r] = 1'b1;
                active_nxt       = active_r + ACT_W'(1);
              end
            end
            CMD_REMOVE: begin
              if (hit) begin
                valid_nxt[idx_r] = 1'b0;
                active_nxt       = active_r - ACT_W'(1);
              end
            end
            default: wr.upd = 1'b0;
          endcase
          if (hit) begin
            if (pend_v_r) begin
              out_nxt       = pend_r;
              out_valid_nxt = 1'b1;
            end
            pend_nxt   = hit_res;
            pend_v_nxt = 1'b1;
          end
          if (scan_done) begin
            state_nxt = S_FLUSH;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_READ;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          if (pend_v_r) begin
            out_nxt       = pend_r;
            out_nxt.last  = 1'b1;
            out_valid_nxt = 1'b1;
            pend_v_nxt    = 1'b0;
          end else begin
            out_nxt            = '0;
            out_nxt.last       = 1'b1;
            case (cmd_r)
              CMD_ADD: begin
                out_nxt.status = ST_FULL;
                out_valid_nxt  = 1'b1;
              end
              CMD_REMOVE: begin
                out_nxt.status = ST_NOT_FOUND;
                out_valid_nxt  = 1'b1;
              end
              default: out_nxt.status = ST_OK;
            endcase
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      valid_r     <= '0;
      active_r    <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= STEP_W'(1);
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      valid_r     <= valid_nxt;
      active_r    <= active_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        step_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    owner_r  <= owner_nxt;
    period_r <= period_nxt;
    pend_r   <= pend_nxt;
    out_r    <= out_nxt;
  end

`ifndef SYNTHESIS
  a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r <= ACT_FULL)
    else $error("active slot count above table size");

  a_active_count: assert property (@(posedge clk) disable iff (!rst_n)
    active_r == ACT_W'($countones(valid_r)))
    else $error("active slot count differs from valid bits");

  a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !pend_v_r)
    else $error("pending result left behind at end of item");

  a_walk_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) && !(hit && pend_v_r && !out_free) && !scan_done
      |=> (state_r == S_READ) && (idx_r == $past(idx_r) + IDX_W'(1)))
    else $error("slot walk skipped or repeated a slot");
`endif

endmodule
